[sv/rgb_to_hsv_pixel_defines.svh]
// ----------------------------------------------------------------------------
// rgb_to_hsv_pixel assertion macros
// shared property shapes for the checker, clocked on clk and held off in reset
// ----------------------------------------------------------------------------
`ifndef RGB_TO_HSV_PIXEL_DEFINES_SVH
`define RGB_TO_HSV_PIXEL_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define RGBHSV_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rgb_to_hsv_pixel: same-cycle check failed");

// consequent must hold in the cycle after the antecedent
`define RGBHSV_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rgb_to_hsv_pixel: next-cycle check failed");

`endif

[sv/rgbhsv_pkg.sv]
// ----------------------------------------------------------------------------
// rgbhsv_pkg
// widths and hue constants shared with the checker, plus the sector type
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rgbhsv_pkg;

  localparam int CH_W        = 8;
  localparam int HUE_W       = 15;
  localparam int IN_TDATA_W  = 3 * CH_W;
  localparam int OUT_TDATA_W = 32;

  // quotient bits of the two dividers
  localparam int HQ_BITS = 12;
  localparam int SQ_BITS = 8;
  localparam int DIV_STAGES = HQ_BITS;

  // dividend widths: 3840*mag and 255*delta
  localparam int NUM_H_W = 20;
  localparam int NUM_S_W = 16;

  localparam logic [HUE_W-1:0] HUE_SIXTH = 15'd3840;
  localparam logic [HUE_W-1:0] HUE_GREEN = 15'd7680;
  localparam logic [HUE_W-1:0] HUE_BLUE  = 15'd15360;
  localparam logic [HUE_W-1:0] HUE_FULL  = 15'd23040;

  typedef enum logic [1:0] {
    SEC_RED,
    SEC_GREEN,
    SEC_BLUE
  } sector_t;

endpackage

[sv/rgb_to_hsv_pixel.sv]
// ----------------------------------------------------------------------------
// rgb_to_hsv_pixel
// pipelined 8-bit rgb to hsv converter; while not stalled, one pixel per clock
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one pixel per beat: s_tdata = {blue, green, red}, red in [7:0].
//   m_* carries one result per beat: m_tdata = {0, value, saturation, hue},
//   hue in [14:0] (1/64 degree), saturation in [22:15], value in [30:23].
//   A pixel passes the input, classify and dividend registers, 12 restoring
//   divider stages and the output register on its way to m_tvalid. The divider
//   stages, which make up most of the latency, give one hue quotient bit each
//   and the last ones the saturation bits. One pixel per clock unless stalled.
//   The whole pipeline moves on one enable: when m_tvalid is high and m_tready
//   low it holds, s_tready drops, and nothing is lost or repeated. Bubbles
//   travel as cleared valid bits.
//   Reset (rst, synchronous, active high) clears all valid bits together;
//   s_tready is high right after reset.
//   Grey pixels (all channels equal) give hue 0 and saturation 0.
//   Ties for the largest channel favor red, then green.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rgb_to_hsv_pixel (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // red [7:0], green [15:8], blue [23:16]
  input  logic [rgbhsv_pkg::IN_TDATA_W-1:0]  s_tdata,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // hue [14:0], saturation [22:15], value [30:23], zero [31]
  output logic [rgbhsv_pkg::OUT_TDATA_W-1:0] m_tdata
);
  import rgbhsv_pkg::*;

  localparam int NS = DIV_STAGES;

  logic en;

  // input register
  logic            v0;
  logic [CH_W-1:0] r0, g0, b0;

  // classify stage
  logic [CH_W-1:0] max_rg, mx_c, min_rg, mn_c, dl_c, da, db, mag_c;
  sector_t         sec_c;
  logic            neg_c;

  logic            v1;
  logic [CH_W-1:0] mx1, dl1, mag1;
  sector_t         sec1;
  logic            neg1;

  // divider pipeline, index 0 holds the dividends
  logic [NS:0]          vp;
  logic [NUM_H_W-1:0]   remh [0:NS];
  logic [NUM_S_W-1:0]   rems [0:NS];
  logic [HQ_BITS-1:0]   qh   [0:NS];
  logic [SQ_BITS-1:0]   qs   [0:NS];
  logic [CH_W-1:0]      dv   [0:NS];
  logic [CH_W-1:0]      mxp  [0:NS];
  sector_t              secp [0:NS];
  logic                 negp [0:NS];

  // final stage
  logic [HUE_W-1:0]   cw, base, hue_c;
  logic [SQ_BITS-1:0] sat_c;

  assign en       = !m_tvalid || m_tready;
  // no beat is taken while reset holds the valid bits clear
  assign s_tready = en && !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (en) begin
      v0 <= s_tvalid;
    end
    if (en) begin
      r0 <= s_tdata[CH_W-1:0];
      g0 <= s_tdata[2*CH_W-1:CH_W];
      b0 <= s_tdata[3*CH_W-1:2*CH_W];
    end
  end

  always_comb begin
    max_rg = (r0 > g0) ? r0 : g0;
    mx_c   = (max_rg > b0) ? max_rg : b0;
    min_rg = (r0 < g0) ? r0 : g0;
    mn_c   = (min_rg < b0) ? min_rg : b0;
    dl_c   = mx_c - mn_c;
    if (r0 >= mx_c) begin
      sec_c = SEC_RED;
    end else if (g0 >= mx_c) begin
      sec_c = SEC_GREEN;
    end else begin
      sec_c = SEC_BLUE;
    end
    case (sec_c)
      SEC_RED: begin
        da = g0;
        db = b0;
      end
      SEC_GREEN: begin
        da = b0;
        db = r0;
      end
      default: begin
        da = r0;
        db = g0;
      end
    endcase
    neg_c = da < db;
    mag_c = neg_c ? (db - da) : (da - db);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= v0;
    end
    if (en) begin
      mx1  <= mx_c;
      dl1  <= dl_c;
      mag1 <= mag_c;
      sec1 <= sec_c;
      neg1 <= neg_c;
    end
  end

  // dividends: 3840*mag = mag*4096 - mag*256, 255*delta = delta*256 - delta
  always_ff @(posedge clk) begin
    if (en) begin
      remh[0] <= {mag1, 12'b0} - {4'b0, mag1, 8'b0};
      rems[0] <= {dl1, 8'b0} - {8'b0, dl1};
      qh[0]   <= '0;
      qs[0]   <= '0;
      dv[0]   <= dl1;
      mxp[0]  <= mx1;
      secp[0] <= sec1;
      negp[0] <= neg1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vp <= '0;
    end else if (en) begin
      vp <= {vp[NS-1:0], v1};
    end
  end

  // one restoring step per stage: hue quotient bit I, and saturation bit I
  // once I falls inside the saturation quotient
  for (genvar k = 0; k < NS; k++) begin : g_div
    localparam int I = HQ_BITS - 1 - k;

    logic [NUM_H_W-1:0] dh;
    logic [NUM_S_W-1:0] ds;
    logic               hge, sge;

    assign dh  = NUM_H_W'(dv[k]) << I;
    assign ds  = NUM_S_W'(mxp[k]) << I;
    assign hge = remh[k] >= dh;
    assign sge = (I < SQ_BITS) && (rems[k] >= ds);

    always_ff @(posedge clk) begin
      if (en) begin
        remh[k+1] <= hge ? (remh[k] - dh) : remh[k];
        rems[k+1] <= sge ? (rems[k] - ds) : rems[k];
        qh[k+1]   <= qh[k] | (HQ_BITS'(hge) << I);
        qs[k+1]   <= qs[k] | (SQ_BITS'(sge) << I);
        dv[k+1]   <= dv[k];
        mxp[k+1]  <= mxp[k];
        secp[k+1] <= secp[k];
        negp[k+1] <= negp[k];
      end
    end
  end

  // negative diff rounds toward minus infinity: subtract the ceiling
  always_comb begin
    cw = HUE_W'(qh[NS]) + HUE_W'(remh[NS] != '0);
    case (secp[NS])
      SEC_RED:   base = '0;
      SEC_GREEN: base = HUE_GREEN;
      SEC_BLUE:  base = HUE_BLUE;
      default:   base = '0;
    endcase
    if (!negp[NS]) begin
      hue_c = base + HUE_W'(qh[NS]);
    end else if (base == '0 && cw != '0) begin
      hue_c = HUE_FULL - cw;
    end else begin
      hue_c = base - cw;
    end
    sat_c = qs[NS];
    // grey pixel
    if (dv[NS] == '0) begin
      hue_c = '0;
      sat_c = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= vp[NS];
    end
    if (en) begin
      m_tdata <= {1'b0, mxp[NS], sat_c, hue_c};
    end
  end

endmodule

[sv/rgbhsv_checker.sv]
// ----------------------------------------------------------------------------
// rgbhsv_checker
// port-level checks on the rgb to hsv converter, bound to its top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "rgb_to_hsv_pixel_defines.svh"

module rgbhsv_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              s_tready,
  input logic                              m_tvalid,
  input logic                              m_tready,
  input logic [rgbhsv_pkg::OUT_TDATA_W-1:0] m_tdata
);
  import rgbhsv_pkg::*;

  // a stalled result beat holds
  `RGBHSV_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

  // a stalled output stops intake
  `RGBHSV_ASSERT_SAME(a_stall_blocks_in, m_tvalid && !m_tready, !s_tready)

  // hue stays below a full turn and the pad bit is zero
  `RGBHSV_ASSERT_SAME(a_hue_range, m_tvalid, m_tdata[14:0] < HUE_FULL && !m_tdata[31])

  // zero saturation only for grey, which has zero hue
  `RGBHSV_ASSERT_SAME(a_grey_hue, m_tvalid && m_tdata[22:15] == '0, m_tdata[14:0] == '0)

endmodule

bind rgb_to_hsv_pixel rgbhsv_checker u_rgbhsv_checker (.*);
